// File: rtl/msp_pkg.sv
// Shared types, constants and helpers for the matrix saddle point finder.
package msp_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 4;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } msp_job_t;

  // zero reads as one, anything above the maximum saturates
  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > maxv) begin
      r = CFG_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/msp_if.sv
// Valid/ready channel interfaces for matrix elements and saddle point results.
interface msp_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [msp_pkg::DATA_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface msp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [msp_pkg::IDX_W-1:0]         row_index;
  logic [msp_pkg::IDX_W-1:0]         col_index;
  logic signed [msp_pkg::DATA_W-1:0] point_value;
  logic                              last;

  modport source (output valid, output found, output row_index, output col_index,
                  output point_value, output last, input ready);
  modport sink   (input valid, input found, input row_index, input col_index,
                  input point_value, input last, output ready);
endinterface

// File: rtl/msp_ram.sv
// Generic single write port, single read port RAM with registered read.
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/msp_loader.sv
// Element loader: store write position, element count and resync after a size change.
module msp_loader #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF,
  localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msp_pkg::CFG_W-1:0]    rows_i,
  input  logic [msp_pkg::CFG_W-1:0]    cols_i,
  input  logic                         accept_i,
  output logic                         ready_o,
  output logic [AW-1:0]                waddr_o,
  output msp_pkg::msp_job_t            job_o
);

  localparam int RMAX  = (MAX_ROWS < 15) ? MAX_ROWS : 15;
  localparam int CMAX  = (MAX_COLS < 15) ? MAX_COLS : 15;
  localparam int CW    = $clog2(RMAX * CMAX + 1);
  localparam int SW    = msp_pkg::CFG_W;

  typedef enum logic [1:0] {L_RUN, L_TOTAL, L_WALK} lstate_e;

  lstate_e         state_q;
  logic [CW-1:0]   count_q, total_q, walk_q;
  logic [SW-1:0]   row_q, col_q;
  logic [SW-1:0]   row_step, col_step;
  logic [2*SW-1:0] prod;
  logic            run_done;

  assign prod = rows_i * cols_i;

  always_comb begin
    if (col_q + SW'(1) == cols_i) begin
      col_step = '0;
      row_step = row_q + SW'(1);
    end else begin
      col_step = col_q + SW'(1);
      row_step = row_q;
    end
  end

  assign run_done = (count_q + CW'(1)) == total_q;
  assign ready_o  = (state_q == L_RUN) && !cfg_we_i;
  assign waddr_o  = AW'(row_q) * AW'(MAX_COLS) + AW'(col_q);

  assign job_o.start = accept_i && run_done;
  assign job_o.rows  = rows_i;
  assign job_o.cols  = cols_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_TOTAL;
      count_q <= '0;
      total_q <= '0;
      walk_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else if (cfg_we_i) begin
      state_q <= L_TOTAL;
    end else begin
      case (state_q)
        L_RUN: begin
          if (accept_i) begin
            if (run_done) begin
              count_q <= '0;
              row_q   <= '0;
              col_q   <= '0;
            end else begin
              count_q <= count_q + CW'(1);
              row_q   <= row_step;
              col_q   <= col_step;
            end
          end
        end
        L_TOTAL: begin
          total_q <= CW'(prod);
          walk_q  <= '0;
          row_q   <= '0;
          col_q   <= '0;
          if ((2*SW)'(count_q) >= prod) begin
            count_q <= '0;
            state_q <= L_RUN;
          end else begin
            state_q <= L_WALK;
          end
        end
        L_WALK: begin
          // step the write position up to the current count, one element a cycle
          if (walk_q == count_q) begin
            state_q <= L_RUN;
          end else begin
            walk_q <= walk_q + CW'(1);
            row_q  <= row_step;
            col_q  <= col_step;
          end
        end
        default: state_q <= L_TOTAL;
      endcase
    end
  end

endmodule

// File: rtl/msp_scan.sv
// Scan sequencer: row minima and column maxima through one shared comparator.
module msp_scan #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF,
  localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msp_pkg::msp_job_t                 job_i,
  output logic                              busy_o,
  output logic [AW-1:0]                     raddr_o,
  input  logic [msp_pkg::DATA_W-1:0]        rdata_i,
  msp_out_if.source                         out_ch
);

  localparam int SW    = msp_pkg::CFG_W;
  localparam int DW    = msp_pkg::DATA_W;
  localparam int IW    = msp_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MIN_RD, S_MIN_CMP, S_MAX_RD, S_MAX_CMP, S_PUSH, S_FINAL
  } sstate_e;

  sstate_e        state_q;
  logic [SW-1:0]  rows_q, cols_q, row_q, idx_q, mincol_q, maxrow_q;
  logic [DW-1:0]  best_q, minval_q;
  logic           pend_valid_q;
  logic [SW-1:0]  pend_row_q, pend_col_q;
  logic [DW-1:0]  pend_val_q;

  logic           out_valid_q, out_found_q, out_last_q;
  logic [IW-1:0]  out_row_q, out_col_q;
  logic [DW-1:0]  out_val_q;

  logic [DW-1:0]  cmp_a, cmp_b;
  logic           cmp_lt, take, out_free, push_out;
  logic [DW-1:0]  best_n;
  logic [SW-1:0]  pick_n;

  // shared comparator: a < b, signed
  always_comb begin
    if (state_q == S_MAX_CMP) begin
      cmp_a = best_q;
      cmp_b = rdata_i;
    end else begin
      cmp_a = rdata_i;
      cmp_b = best_q;
    end
  end
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  assign take   = (idx_q == '0) || cmp_lt;
  assign best_n = take ? rdata_i : best_q;
  assign pick_n = take ? idx_q : ((state_q == S_MAX_CMP) ? maxrow_q : mincol_q);

  always_comb begin
    if (state_q == S_MAX_RD) begin
      raddr_o = AW'(idx_q) * AW'(MAX_COLS) + AW'(mincol_q);
    end else begin
      raddr_o = AW'(row_q) * AW'(MAX_COLS) + AW'(idx_q);
    end
  end

  assign out_free = !out_valid_q || out_ch.ready;
  assign push_out = out_free && ((state_q == S_PUSH && pend_valid_q) || state_q == S_FINAL);
  assign busy_o   = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      rows_q       <= '0;
      cols_q       <= '0;
      row_q        <= '0;
      idx_q        <= '0;
    end else begin
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (job_i.start) begin
            rows_q  <= job_i.rows;
            cols_q  <= job_i.cols;
            row_q   <= '0;
            idx_q   <= '0;
            state_q <= S_MIN_RD;
          end
        end
        S_MIN_RD: state_q <= S_MIN_CMP;
        S_MIN_CMP: begin
          best_q   <= best_n;
          mincol_q <= pick_n;
          if (idx_q + SW'(1) == cols_q) begin
            minval_q <= best_n;
            idx_q    <= '0;
            state_q  <= S_MAX_RD;
          end else begin
            idx_q   <= idx_q + SW'(1);
            state_q <= S_MIN_RD;
          end
        end
        S_MAX_RD: state_q <= S_MAX_CMP;
        S_MAX_CMP: begin
          best_q   <= best_n;
          maxrow_q <= pick_n;
          if (idx_q + SW'(1) == rows_q) begin
            idx_q <= '0;
            if (pick_n == row_q) begin
              state_q <= S_PUSH;
            end else if (row_q + SW'(1) == rows_q) begin
              state_q <= S_FINAL;
            end else begin
              row_q   <= row_q + SW'(1);
              state_q <= S_MIN_RD;
            end
          end else begin
            idx_q   <= idx_q + SW'(1);
            state_q <= S_MAX_RD;
          end
        end
        S_PUSH: begin
          // the held point is known not to be the last once a new one turns up
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_found_q <= 1'b1;
              out_row_q   <= IW'(pend_row_q);
              out_col_q   <= IW'(pend_col_q);
              out_val_q   <= pend_val_q;
              out_last_q  <= 1'b0;
            end
            pend_valid_q <= 1'b1;
            pend_row_q   <= row_q;
            pend_col_q   <= mincol_q;
            pend_val_q   <= minval_q;
            if (row_q + SW'(1) == rows_q) begin
              state_q <= S_FINAL;
            end else begin
              row_q   <= row_q + SW'(1);
              state_q <= S_MIN_RD;
            end
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_found_q  <= pend_valid_q;
            out_row_q    <= pend_valid_q ? IW'(pend_row_q) : '0;
            out_col_q    <= pend_valid_q ? IW'(pend_col_q) : '0;
            out_val_q    <= pend_valid_q ? pend_val_q : '0;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.found       = out_found_q;
  assign out_ch.row_index   = out_row_q;
  assign out_ch.col_index   = out_col_q;
  assign out_ch.point_value = out_val_q;
  assign out_ch.last        = out_last_q;

  a_final_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && out_free) |=> (out_valid_q && out_last_q))
    else $error("final result not issued");

  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> out_last_q)
    else $error("not-found result without last");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("saddle point left pending after run");

endmodule

// File: rtl/matrix_saddle_point_finder.sv
// Top level of the matrix saddle point finder: config registers, loader, store and scan.
//
// Elements are taken one per cycle in row-major order and written to a
// MAX_ROWS*MAX_COLS word store. The element that completes a rows x cols
// matrix starts a scan, during which no element is accepted. Each row is
// scanned for its minimum and then that column for its maximum, each store
// read taking a read state and a compare state, since every store read goes
// through the single registered read port and the single comparator; a row
// that yields a saddle point adds a push state, the last result adds a final
// state, and a stall on the result channel holds either of those states.
// Results come out in ascending row order, the last one flagged; a matrix with
// no saddle point gives one not-found result. After a write to either size
// register the block is not ready while it recomputes the store write
// position for the elements already loaded.
module matrix_saddle_point_finder #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  msp_in_if.sink                          in_ch,
  msp_out_if.source                       out_ch,
  input  logic                            cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msp_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [msp_pkg::CFG_W-1:0] rows_cfg_q, cols_cfg_q, rows_eff, cols_eff;
  logic                      load_ready, scan_busy, accept;
  logic [AW-1:0]             waddr, raddr;
  logic [msp_pkg::DATA_W-1:0] rdata;
  msp_pkg::msp_job_t         job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= msp_pkg::SIZE_RESET;
      cols_cfg_q <= msp_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msp_pkg::REG_ROWS: rows_cfg_q <= cfg_data_i;
        msp_pkg::REG_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_eff = msp_pkg::clamp_size(rows_cfg_q, MAX_ROWS);
  assign cols_eff = msp_pkg::clamp_size(cols_cfg_q, MAX_COLS);

  assign in_ch.ready = load_ready && !scan_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  msp_loader #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_loader (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .rows_i   (rows_eff),
    .cols_i   (cols_eff),
    .accept_i (accept),
    .ready_o  (load_ready),
    .waddr_o  (waddr),
    .job_o    (job)
  );

  msp_ram #(
    .WIDTH (msp_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (in_ch.element),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  msp_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job),
    .busy_o  (scan_busy),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .out_ch  (out_ch)
  );

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_busy |-> !in_ch.ready)
    else $error("element accepted during scan");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.start |=> scan_busy)
    else $error("scan did not start after last element");

  a_start_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.start |-> accept)
    else $error("scan started without an element");

endmodule
